>>> sv/thrconv_pkg.sv
`timescale 1ns / 1ps

package thrconv_pkg;

  localparam int unsigned PixBits     = 8;
  localparam int unsigned CoefBits    = 16;
  localparam int unsigned LaneBits    = 16;
  localparam int unsigned LanesPerSet = 4;
  localparam int unsigned NumTaps     = 9;
  localparam int unsigned CentreTap   = 4;
  localparam int unsigned ProdBits    = PixBits + 1 + CoefBits;
  localparam int unsigned GroupBits   = ProdBits + 2;
  localparam int unsigned SumBits     = ProdBits + 4;
  localparam int unsigned WsumBits    = CoefBits + 4;
  localparam int unsigned NumBits     = SumBits + 1;
  localparam int unsigned QuotBits    = PixBits;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 64;

  localparam logic [CfgIdxBits-1:0] CfgModeBelow = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgCoefA     = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgCoefB     = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] CfgCoefC     = CfgIdxBits'(3);

  localparam logic [PixBits-1:0] PixMax = '1;

  typedef logic [PixBits-1:0]         pix_t;
  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [WsumBits-1:0] wsum_t;

  typedef pix_t  [NumTaps-1:0] pix_vec_t;
  typedef coef_t [NumTaps-1:0] coef_vec_t;
  typedef prod_t [NumTaps-1:0] prod_vec_t;

  typedef struct packed {
    prod_vec_t prod;
    wsum_t     div;
    pix_t      centre;
  } prod_beat_t;

  typedef struct packed {
    logic [NumBits-1:0]  num_mag;
    logic [WsumBits-1:0] den_mag;
    logic                pos;
    logic                den_zero;
    pix_t                centre;
  } quot_req_t;

endpackage

>>> sv/thrconv_weight.sv
`timescale 1ns / 1ps

module thrconv_weight import thrconv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  pix_vec_t   pix_i,
  input  pix_t       limit_i,
  input  logic       mode_below_i,
  input  coef_vec_t  coef_i,
  input  coef_t      divisor_i,
  output logic       valid_o,
  output prod_beat_t beat_o
);

  pix_vec_t  pix_sel_d, pix_sel_q;
  coef_vec_t coef_sel_d, coef_sel_q;
  pix_t      centre1_q, centre2_q;
  prod_vec_t prod_d, prod_q;
  wsum_t     wsum;
  wsum_t     div_d, div_q;
  logic      valid1_q, valid2_q;

  function automatic logic near_f(pix_t px, pix_t ctr, pix_t lim);
    pix_t diff;
    diff = (px > ctr) ? (px - ctr) : (ctr - px);
    return diff < lim;
  endfunction

  always_comb begin
    for (int unsigned i = 0; i < NumTaps; i++) begin
      if (i == CentreTap || near_f(pix_i[i], pix_i[CentreTap], limit_i)) begin
        pix_sel_d[i]  = pix_i[i];
        coef_sel_d[i] = coef_i[i];
      end else begin
        pix_sel_d[i]  = pix_i[CentreTap];
        coef_sel_d[i] = mode_below_i ? '0 : coef_i[i];
      end
    end
  end

  always_comb begin
    wsum = '0;
    for (int unsigned i = 0; i < NumTaps; i++) begin
      prod_d[i] = $signed({1'b0, pix_sel_q[i]}) * $signed(coef_sel_q[i]);
      wsum      = wsum + WsumBits'($signed(coef_sel_q[i]));
    end
    div_d = mode_below_i ? wsum : WsumBits'($signed(divisor_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_sel_q  <= pix_sel_d;
      coef_sel_q <= coef_sel_d;
      centre1_q  <= pix_i[CentreTap];
      prod_q     <= prod_d;
      div_q      <= div_d;
      centre2_q  <= centre1_q;
    end
  end

  assign valid_o = valid2_q;
  assign beat_o  = '{prod: prod_q, div: div_q, centre: centre2_q};

endmodule

>>> sv/thrconv_sum.sv
`timescale 1ns / 1ps

module thrconv_sum import thrconv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  prod_beat_t beat_i,
  output logic       valid_o,
  output quot_req_t  req_o
);

  localparam int unsigned TapsPerGroup = 3;
  localparam int unsigned NumGroups    = NumTaps / TapsPerGroup;

  logic [NumGroups-1:0][GroupBits-1:0] grp_d, grp_q;
  wsum_t              div1_q, div2_q;
  wsum_t              div_adj, half;
  pix_t               centre1_q, centre2_q;
  logic [NumBits-1:0] num_d, num_q;
  quot_req_t          req_d, req_q;
  logic [2:0]         vld_q;

  always_comb begin
    for (int unsigned g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int unsigned t = 0; t < TapsPerGroup; t++) begin
        grp_d[g] = GroupBits'($signed(grp_d[g])
                   + $signed(beat_i.prod[g * TapsPerGroup + t]));
      end
    end
  end

  // Half the divisor, truncated toward zero, plus the group sums.
  always_comb begin
    div_adj = div1_q + wsum_t'(div1_q[WsumBits-1]);
    half    = div_adj >>> 1;
    num_d   = NumBits'(half);
    for (int unsigned g = 0; g < NumGroups; g++) begin
      num_d = num_d + NumBits'($signed(grp_q[g]));
    end
  end

  always_comb begin
    req_d.num_mag  = num_q[NumBits-1] ? -num_q : num_q;
    req_d.den_mag  = div2_q[WsumBits-1] ? -div2_q : div2_q;
    req_d.pos      = (num_q[NumBits-1] == div2_q[WsumBits-1]);
    req_d.den_zero = (div2_q == '0);
    req_d.centre   = centre2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q     <= grp_d;
      div1_q    <= beat_i.div;
      centre1_q <= beat_i.centre;
      num_q     <= num_d;
      div2_q    <= div1_q;
      centre2_q <= centre1_q;
      req_q     <= req_d;
    end
  end

  assign valid_o = vld_q[2];
  assign req_o   = req_q;

endmodule

>>> sv/thrconv_div.sv
`timescale 1ns / 1ps

module thrconv_div import thrconv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  quot_req_t req_i,
  output logic      valid_o,
  output pix_t      pix_o
);

  typedef struct packed {
    logic [NumBits-1:0]  rem;
    logic [WsumBits-1:0] den;
    logic [QuotBits-1:0] quot;
    logic                pos;
    logic                den_zero;
    logic                sat;
    pix_t                centre;
  } step_t;

  step_t             step_d [QuotBits+1];
  step_t             step_q [QuotBits+1];
  logic [NumBits:0]  trial  [QuotBits];
  logic [QuotBits:0] vld_q;
  step_t             last;

  // The first stage flags quotients above the pixel range; the rest form one
  // quotient bit each, most significant first.
  always_comb begin
    step_d[0].rem      = req_i.num_mag;
    step_d[0].den      = req_i.den_mag;
    step_d[0].quot     = '0;
    step_d[0].pos      = req_i.pos;
    step_d[0].den_zero = req_i.den_zero;
    step_d[0].sat      = req_i.num_mag >= (NumBits'(req_i.den_mag) << QuotBits);
    step_d[0].centre   = req_i.centre;
    for (int unsigned k = 0; k < QuotBits; k++) begin
      trial[k] = {1'b0, step_q[k].rem}
                 - ({1'b0, NumBits'(step_q[k].den)} << (QuotBits - 1 - k));
      step_d[k+1] = step_q[k];
      if (!trial[k][NumBits]) begin
        step_d[k+1].rem                    = trial[k][NumBits-1:0];
        step_d[k+1].quot[QuotBits - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotBits-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned k = 0; k <= QuotBits; k++) begin
        step_q[k] <= step_d[k];
      end
    end
  end

  always_comb begin
    last = step_q[QuotBits];
    if (last.den_zero) begin
      pix_o = last.centre;
    end else if (!last.pos) begin
      pix_o = '0;
    end else if (last.sat) begin
      pix_o = PixMax;
    end else begin
      pix_o = last.quot;
    end
  end

  assign valid_o = vld_q[QuotBits];

endmodule

>>> sv/thresholded_3x3_convolution.sv
// Thresholded 3x3 convolution: one filtered pixel for each 3x3 window.
// Input channel: in_valid_i / in_ready_o carry the nine window pixels and the
// per-pixel difference limit; a transfer takes place on a clock edge where both
// are high. Output channel: out_valid_o / out_ready_i carry pix_out_o.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 mode,
// 1 and 2 coefficient sets, 3 bottom-right coefficient and divisor) on the
// same edge. The user must see that registers are written only while no
// window is in flight; the block does not enforce this. Throughput is one
// window per clock unless the output stalls. Stages: two of thresholding and
// multiplication, three of summation and sign handling, nine in the divider
// (a range check and one quotient bit per stage), and the output register.
// If the output register holds a result that the receiver does not take, the
// whole pipeline holds still and in_ready_o drops in the same cycle; nothing is
// lost or repeated, and ready returns in the cycle the receiver takes it.
// Reset (rst_ni low) empties the pipeline and clears the configuration
// registers to zero.
`timescale 1ns / 1ps

module thresholded_3x3_convolution import thrconv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             pix_top_left_i,
  input  logic [7:0]             pix_top_i,
  input  logic [7:0]             pix_top_right_i,
  input  logic [7:0]             pix_left_i,
  input  logic [7:0]             pix_centre_i,
  input  logic [7:0]             pix_right_i,
  input  logic [7:0]             pix_bottom_left_i,
  input  logic [7:0]             pix_bottom_i,
  input  logic [7:0]             pix_bottom_right_i,
  input  logic [7:0]             diff_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             pix_out_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  logic       mode_q;
  coef_vec_t  coef_q;
  coef_t      divisor_q;
  pix_vec_t   pix_vec;
  logic       pipe_en;
  logic       w_valid;
  prod_beat_t beat;
  logic       sum_valid;
  quot_req_t  req;
  logic       div_valid;
  pix_t       div_pix;
  logic       out_valid_q;
  pix_t       out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      coef_q    <= '0;
      divisor_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgModeBelow: begin
          mode_q <= cfg_wdata_i[0];
        end
        CfgCoefA: begin
          for (int unsigned i = 0; i < LanesPerSet; i++) begin
            coef_q[i] <= cfg_wdata_i[i * LaneBits +: CoefBits];
          end
        end
        CfgCoefB: begin
          for (int unsigned i = 0; i < LanesPerSet; i++) begin
            coef_q[LanesPerSet + i] <= cfg_wdata_i[i * LaneBits +: CoefBits];
          end
        end
        CfgCoefC: begin
          coef_q[NumTaps-1] <= cfg_wdata_i[CoefBits-1:0];
          divisor_q         <= cfg_wdata_i[LaneBits +: CoefBits];
        end
        default: begin
        end
      endcase
    end
  end

  assign pix_vec = {pix_bottom_right_i, pix_bottom_i, pix_bottom_left_i,
                    pix_right_i, pix_centre_i, pix_left_i,
                    pix_top_right_i, pix_top_i, pix_top_left_i};

  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  thrconv_weight u_weight (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .valid_i      (in_valid_i),
    .pix_i        (pix_vec),
    .limit_i      (diff_limit_i),
    .mode_below_i (mode_q),
    .coef_i       (coef_q),
    .divisor_i    (divisor_q),
    .valid_o      (w_valid),
    .beat_o       (beat)
  );

  thrconv_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (w_valid),
    .beat_i  (beat),
    .valid_o (sum_valid),
    .req_o   (req)
  );

  thrconv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sum_valid),
    .req_i   (req),
    .valid_o (div_valid),
    .pix_o   (div_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_pix_q <= div_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_out_o   = out_pix_q;

`ifndef NO_ASSERTIONS
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(w_valid) && $stable(sum_valid) && $stable(div_valid))
    else $error("pipeline moved while stalled");

  a_out_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && div_valid |=> out_valid_o && (pix_out_o == $past(div_pix)))
    else $error("divider result not captured in the output register");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !div_valid |=> !out_valid_o)
    else $error("output register kept a result after its transfer");
`endif

endmodule
